@@ rtl/core/i2cs_pkg.sv @@
// Shared types, codes and helpers for the sensor read sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2cs_pkg;

  localparam int unsigned MaxDataBytes = 6;
  localparam int unsigned DataW        = 8 * MaxDataBytes;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 24;
  localparam int unsigned InTdataW     = 104;
  localparam int unsigned OutTdataW    = 64;
  localparam logic [15:0] TimeoutReset = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEV_ADDR  = 3'd0,
    CFG_CMD_LEN   = 3'd1,
    CFG_CMD_BYTES = 3'd2,
    CFG_DATA_SIZE = 3'd3,
    CFG_CONV_MS   = 3'd4,
    CFG_CACHE_MS  = 3'd5,
    CFG_TIMEOUT   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PENDING = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REPLY_OK   = 2'd0,
    REPLY_BUSY = 2'd1
  } reply_e;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_CMD   = 6'b000010,
    PH_WAIT  = 6'b000100,
    PH_REQ   = 6'b001000,
    PH_READY = 6'b010000,
    PH_ERROR = 6'b100000
  } phase_e;

  // Settings the sequencer actually uses; the address and command bytes
  // belong to the bus driver and are not kept here.
  typedef struct packed {
    logic [1:0]  cmd_len;
    logic [2:0]  data_size;
    logic [15:0] conv_ms;
    logic [15:0] cache_ms;
    logic [15:0] timeout_ms;
  } cfg_t;

  // Poll transaction, last field in the low bits.
  typedef struct packed {
    logic [DataW-1:0] rx_data;
    logic [7:0]       rx_count;
    logic [1:0]       start_reply;
    logic             bus_done_ok;
    logic             bus_idle;
    logic [7:0]       room_bytes;
    logic [31:0]      now_ms;
  } item_t;

  // Result transaction, last field in the low bits.
  typedef struct packed {
    logic             start_read;
    logic             write_with_stop;
    logic             start_write;
    logic             bus_reset;
    logic [2:0]       data_len;
    logic [DataW-1:0] data_out;
    logic [1:0]       status;
  } result_t;

  // Keep the first n bytes of a word, zero the rest.
  function automatic logic [DataW-1:0] keep_bytes(logic [DataW-1:0] d, logic [2:0] n);
    logic [DataW-1:0] r;
    r = d;
    for (int i = 0; i < MaxDataBytes; i++) begin
      if (3'(i) >= n) begin
        r[8*i +: 8] = 8'd0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/i2cs_cfg.sv @@
// Configuration register file of the sensor read sequencer.
// Depends on i2cs_pkg.
`default_nettype none

module i2cs_cfg import i2cs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_wr_en_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr_en_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CMD_LEN:   cfg_d.cmd_len    = cfg_wdata_i[1:0];
        CFG_DATA_SIZE: cfg_d.data_size  = cfg_wdata_i[2:0];
        CFG_CONV_MS:   cfg_d.conv_ms    = cfg_wdata_i[15:0];
        CFG_CACHE_MS:  cfg_d.cache_ms   = cfg_wdata_i[15:0];
        CFG_TIMEOUT:   cfg_d.timeout_ms = cfg_wdata_i[15:0];
        // address and command bytes are driver settings; nothing kept
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cmd_len    <= 2'd1;
      cfg_q.data_size  <= 3'd1;
      cfg_q.conv_ms    <= 16'd0;
      cfg_q.cache_ms   <= 16'd0;
      cfg_q.timeout_ms <= TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/i2cs_seq.sv @@
// Sequencer state and per-poll next-state/result logic.
// Depends on i2cs_pkg.
`default_nettype none

module i2cs_seq import i2cs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  step_i,     // consume item_i this cycle
  input  wire item_t item_i,
  output result_t    result_o
);

  phase_e           phase_q, phase_d;
  logic [31:0]      req_time_q, req_time_d;
  logic [31:0]      cache_time_q, cache_time_d;
  logic [DataW-1:0] store_q, store_d;

  logic        simple;
  logic [31:0] elapsed, cache_age;
  logic [2:0]  eff_size, dlv_len;
  logic        cache_hit, timed_out;
  result_t     res;

  assign simple    = (cfg_i.cmd_len == 2'd1);
  assign elapsed   = item_i.now_ms - req_time_q;
  assign cache_age = item_i.now_ms - cache_time_q;
  assign eff_size  = (cfg_i.data_size > 3'(MaxDataBytes)) ? 3'(MaxDataBytes)
                                                          : cfg_i.data_size;
  assign dlv_len   = ({5'd0, eff_size} > item_i.room_bytes) ? item_i.room_bytes[2:0]
                                                            : eff_size;
  assign cache_hit = (cfg_i.cache_ms != 16'd0) && (cache_time_q != 32'd0) &&
                     (cache_age < {16'd0, cfg_i.cache_ms});
  assign timed_out = elapsed > {16'd0, cfg_i.timeout_ms};

  always_comb begin
    res          = '0;
    res.status   = ST_PENDING;
    phase_d      = phase_q;
    req_time_d   = req_time_q;
    cache_time_d = cache_time_q;
    store_d      = store_q;

    if (cache_hit) begin
      res.status   = ST_OK;
      res.data_out = keep_bytes(store_q, dlv_len);
      res.data_len = dlv_len;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (item_i.bus_idle) begin
            res.bus_reset       = 1'b1;
            res.start_write     = 1'b1;
            res.write_with_stop = !simple;
            if (item_i.start_reply == REPLY_BUSY) begin
              res.status = ST_PENDING;
            end else if (item_i.start_reply != REPLY_OK) begin
              phase_d    = PH_ERROR;
              res.status = ST_ERROR;
            end else begin
              req_time_d = item_i.now_ms;
              phase_d    = PH_CMD;
            end
          end
        end
        PH_CMD, PH_WAIT: begin
          if ((phase_q == PH_CMD) && !item_i.bus_idle) begin
            if (timed_out) begin
              phase_d    = PH_ERROR;
              res.status = ST_ERROR;
            end
          end else if ((phase_q == PH_CMD) && !item_i.bus_done_ok) begin
            phase_d    = PH_ERROR;
            res.status = ST_ERROR;
          end else if ((phase_q == PH_CMD) && !simple) begin
            phase_d = PH_WAIT;
          end else if ((phase_q == PH_CMD) || (elapsed >= {16'd0, cfg_i.conv_ms})) begin
            // read start, shared by register-address mode and end of wait
            res.bus_reset  = 1'b1;
            res.start_read = 1'b1;
            if (item_i.start_reply == REPLY_BUSY) begin
              res.status = ST_PENDING;
            end else if (item_i.start_reply != REPLY_OK) begin
              phase_d    = PH_ERROR;
              res.status = ST_ERROR;
            end else begin
              req_time_d = item_i.now_ms;
              phase_d    = PH_REQ;
            end
          end
        end
        PH_REQ: begin
          if (!item_i.bus_idle) begin
            if (timed_out) begin
              phase_d    = PH_ERROR;
              res.status = ST_ERROR;
            end
          end else if (!item_i.bus_done_ok || (item_i.rx_count < {5'd0, eff_size})) begin
            phase_d    = PH_ERROR;
            res.status = ST_ERROR;
          end else begin
            store_d = keep_bytes(item_i.rx_data, eff_size);
            phase_d = PH_READY;
          end
        end
        PH_READY: begin
          res.status   = ST_OK;
          res.data_out = keep_bytes(store_q, dlv_len);
          res.data_len = dlv_len;
          if (cfg_i.cache_ms != 16'd0) begin
            cache_time_d = item_i.now_ms;
          end
          phase_d = PH_IDLE;
        end
        default: begin
          // error phase and any corrupt code: reset the driver, start over
          res.bus_reset = 1'b1;
          res.status    = ST_ERROR;
          phase_d       = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      req_time_q   <= 32'd0;
      cache_time_q <= 32'd0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      req_time_q   <= req_time_d;
      cache_time_q <= cache_time_d;
    end
  end

  // sample store: payload only, read only after a completed read
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      store_q <= store_d;
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

@@ rtl/core/i2c_sensor_read_sequencer_top.sv @@
// Top level of the sensor read sequencer: stream ports, input and result
// registers. Depends on i2cs_pkg, i2cs_cfg and i2cs_seq.
`default_nettype none

// Channel   Dir  Handshake          Payload
// --------  ---  -----------------  ------------------------------------------
// s_axis    in   tvalid/tready      poll transaction, 104-bit tdata
// m_axis    out  tvalid/tready      result transaction, 64-bit tdata
// cfg       in   cfg_wr_en_i only   register index + 24-bit write data
//
// One result per poll. A poll passes through an input register, then the
// step logic of the sequencer into the result register. Throughput is one
// transaction per cycle; the state update happens as a poll moves from the
// input register to the result register, so back-to-back polls see each
// other's state. A stall on m_axis stops both stages; s_axis_tready_o then
// drops only once the input register is occupied. Reset (rst_ni low,
// asynchronous) empties both stages, puts the sequencer in idle and loads
// the configuration defaults; no clearing pass is needed.

module i2c_sensor_read_sequencer_top import i2cs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // poll stream
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  // [31:0] now_ms, [39:32] room_bytes, [40] bus_idle, [41] bus_done_ok,
  // [43:42] start_reply, [51:44] rx_count, [99:52] rx_data, rest zero
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  // result stream
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [1:0] status, [49:2] data_out, [52:50] data_len, [53] bus_reset,
  // [54] start_write, [55] write_with_stop, [56] start_read, rest zero
  output      logic [OutTdataW-1:0] m_axis_tdata_o,
  // configuration writes
  input  wire logic                 cfg_wr_en_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned ItemW = $bits(item_t);
  localparam int unsigned ResW  = $bits(result_t);

  cfg_t    cfg;
  logic    in_vld_q, out_vld_q;
  item_t   item_q;
  result_t res_q, res_next;
  logic    advance;   // result register free or being drained
  logic    step;      // poll moves from input to result register

  assign advance         = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;

  i2cs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_en_i (cfg_wr_en_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  i2cs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (item_q),
    .result_o (res_next)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q <= item_t'(s_axis_tdata_i[ItemW-1:0]);
    end
    if (step) begin
      res_q <= res_next;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutTdataW-ResW){1'b0}}, res_q};

  // stop is only ever asked for together with a write start
  a_stop_with_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!res_q.write_with_stop || res_q.start_write))
    else $error("write_with_stop without start_write");

  // only a delivery carries data
  a_data_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.status != ST_OK)) |-> ((res_q.data_len == 3'd0) &&
                                                 (res_q.data_out == '0)))
    else $error("data on a pending or error result");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.data_len <= 3'(MaxDataBytes)))
    else $error("data_len beyond the data width");

  // a poll that steps always shows up as a result in the next cycle
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("stepped poll produced no result");

endmodule

`default_nettype wire

@@ tb/i2c_sensor_read_sequencer_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sensor read sequencer: directed and random
// polls under varied idling, each result checked against a local predictor.
// Depends on i2cs_pkg and i2c_sensor_read_sequencer_top.

module i2c_sensor_read_sequencer_top_tb;
  import i2cs_pkg::*;

  localparam int unsigned CycleLimit      = 200000;
  localparam int unsigned DrainCycles     = 8;   // two-stage pipe, plus margin
  localparam int unsigned HoldCycles      = 80;
  localparam int unsigned PollsPerSetting = 140;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 cfg_wr_en_i     = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i     = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i     = '0;

  // Predictor state: settings in force and the sequencer's own registers.
  cfg_t             seq_cfg;
  phase_e           seq_phase   = PH_IDLE;
  logic [31:0]      req_stamp   = '0;
  logic [DataW-1:0] sample_hold = '0;
  logic [31:0]      cache_stamp = '0;

  result_t     poll_results_q[$];
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned src_gap_pct    = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_asked     = 0;
  int unsigned hold_granted   = 0;
  int unsigned hold_left      = 0;
  int unsigned setting_no     = 0;
  int unsigned time_span      = 300;
  logic [31:0] ms_clock       = '0;

  i2c_sensor_read_sequencer_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // Bytes actually read: size saturates at six.
  function automatic logic [2:0] read_size();
    return (seq_cfg.data_size > 3'(MaxDataBytes)) ? 3'(MaxDataBytes) : seq_cfg.data_size;
  endfunction

  function automatic logic [DataW-1:0] low_bytes(logic [DataW-1:0] d, int unsigned n);
    logic [DataW-1:0] m;
    m = '0;
    for (int i = 0; i < n; i++) m[8*i +: 8] = 8'hFF;
    return d & m;
  endfunction

  // Stored reading, clamped to the caller's room.
  function automatic result_t delivered(logic [7:0] room);
    result_t    r;
    logic [2:0] n;
    r = '0;
    n = read_size();
    if ({5'd0, n} > room) n = room[2:0];
    r.status   = ST_OK;
    r.data_out = low_bytes(sample_hold, n);
    r.data_len = n;
    return r;
  endfunction

  function automatic logic [1:0] read_reply(logic [1:0] reply, logic [31:0] now);
    if (reply == REPLY_BUSY) return ST_PENDING;
    if (reply != REPLY_OK) begin
      seq_phase = PH_ERROR;
      return ST_ERROR;
    end
    req_stamp = now;
    seq_phase = PH_REQ;
    return ST_PENDING;
  endfunction

  // One poll through the sequencer: updates the state, returns the result.
  function automatic result_t step_sequencer(item_t p);
    result_t     r;
    logic [31:0] elapsed;
    logic [31:0] cache_age;
    logic [1:0]  st;
    logic        simple;
    r         = '0;
    st        = ST_PENDING;
    elapsed   = p.now_ms - req_stamp;
    cache_age = p.now_ms - cache_stamp;
    simple    = (seq_cfg.cmd_len == 2'd1);
    // a fresh cache answers at once and leaves the phase alone
    if (seq_cfg.cache_ms != 16'd0 && cache_stamp != 32'd0 &&
        cache_age < {16'd0, seq_cfg.cache_ms}) begin
      return delivered(p.room_bytes);
    end
    case (seq_phase)
      PH_IDLE: begin
        if (p.bus_idle) begin
          r.bus_reset       = 1'b1;
          r.start_write     = 1'b1;
          r.write_with_stop = !simple;
          if (p.start_reply == REPLY_OK) begin
            req_stamp = p.now_ms;
            seq_phase = PH_CMD;
          end else if (p.start_reply != REPLY_BUSY) begin
            seq_phase = PH_ERROR;
            st        = ST_ERROR;
          end
        end
      end
      PH_CMD: begin
        if (!p.bus_idle) begin
          if (elapsed > {16'd0, seq_cfg.timeout_ms}) begin
            seq_phase = PH_ERROR;
            st        = ST_ERROR;
          end
        end else if (!p.bus_done_ok) begin
          seq_phase = PH_ERROR;
          st        = ST_ERROR;
        end else if (simple) begin
          r.bus_reset  = 1'b1;
          r.start_read = 1'b1;
          st = read_reply(p.start_reply, p.now_ms);
        end else begin
          seq_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (elapsed >= {16'd0, seq_cfg.conv_ms}) begin
          r.bus_reset  = 1'b1;
          r.start_read = 1'b1;
          st = read_reply(p.start_reply, p.now_ms);
        end
      end
      PH_REQ: begin
        if (!p.bus_idle) begin
          if (elapsed > {16'd0, seq_cfg.timeout_ms}) begin
            seq_phase = PH_ERROR;
            st        = ST_ERROR;
          end
        end else if (!p.bus_done_ok || p.rx_count < {5'd0, read_size()}) begin
          seq_phase = PH_ERROR;
          st        = ST_ERROR;
        end else begin
          sample_hold = low_bytes(p.rx_data, read_size());
          seq_phase   = PH_READY;
        end
      end
      PH_READY: begin
        r = delivered(p.room_bytes);
        if (seq_cfg.cache_ms != 16'd0) cache_stamp = p.now_ms;
        seq_phase = PH_IDLE;
        return r;
      end
      default: begin
        // error phase: reset the driver and start over
        r.bus_reset = 1'b1;
        seq_phase   = PH_IDLE;
        st          = ST_ERROR;
      end
    endcase
    r.status = st;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  task automatic check_result(input logic [OutTdataW-1:0] word);
    result_t got;
    result_t want;
    got = word[$bits(result_t)-1:0];
    if (poll_results_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result %0h with no poll outstanding", word);
    end else begin
      want = poll_results_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("data_out", want.data_out, got.data_out);
      compare_field("data_len", want.data_len, got.data_len);
      compare_field("bus_reset", want.bus_reset, got.bus_reset);
      compare_field("start_write", want.start_write, got.start_write);
      compare_field("write_with_stop", want.write_with_stop, got.write_with_stop);
      compare_field("start_read", want.start_read, got.start_read);
      compare_field("tdata padding", '0, word[OutTdataW-1:$bits(result_t)]);
    end
  endtask

  // Result side: tvalid, tready and tdata are settled at the falling edge,
  // so a handshake due at the next rising edge is checked there.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o);
  end

  // Next ready at each rising edge. A requested hold-off is counted down
  // here from HoldCycles, with ready held low meanwhile.
  always @(posedge clk_i) begin
    if (hold_asked != hold_granted) begin
      hold_granted = hold_asked;
      hold_left    = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= rst_ni && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_poll(input item_t p);
    logic [InTdataW-1:0] word;
    logic                accepted;
    word = '0;
    word[$bits(item_t)-1:0] = p;
    accepted = 1'b0;
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    poll_results_q.push_back(step_sequencer(p));
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    // tready is settled at the falling edge for the coming rising edge
    while (!accepted) begin
      @(negedge clk_i);
      accepted = s_axis_tready_o;
      @(posedge clk_i);
    end
  endtask

  task automatic poll(input logic [31:0] now, input logic [7:0] room, input logic idle, ok,
                      input logic [1:0] reply, input logic [7:0] cnt,
                      input logic [DataW-1:0] data);
    item_t p;
    p.now_ms      = now;
    p.room_bytes  = room;
    p.bus_idle    = idle;
    p.bus_done_ok = ok;
    p.start_reply = reply;
    p.rx_count    = cnt;
    p.rx_data     = data;
    send_poll(p);
  endtask

  // Mostly well-formed bus driver behavior for the phase the block is in,
  // with a slice of fully random polls.
  function automatic item_t next_poll();
    item_t       p;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) ms_clock = $urandom;
    else if (pick < 18) ms_clock += $urandom_range(time_span);
    else ms_clock += $urandom_range(2);
    p.now_ms     = ms_clock;
    p.room_bytes = ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom);
    p.rx_data    = DataW'({$urandom, $urandom});
    if ($urandom_range(99) < 8) begin
      p.bus_idle    = 1'($urandom);
      p.bus_done_ok = 1'($urandom);
      p.start_reply = 2'($urandom);
      p.rx_count    = 8'($urandom);
      return p;
    end
    p.bus_idle    = $urandom_range(99) < ((seq_phase == PH_IDLE) ? 90 : 65);
    p.bus_done_ok = $urandom_range(99) < 92;
    pick = $urandom_range(99);
    if (pick < 82) p.start_reply = REPLY_OK;
    else if (pick < 92) p.start_reply = REPLY_BUSY;
    else p.start_reply = 2'($urandom_range(3, 2));
    p.rx_count = ($urandom_range(99) < 90) ? 8'(read_size()) + 8'($urandom_range(2))
                                          : 8'($urandom);
    return p;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_CMD_LEN:   seq_cfg.cmd_len    = value[1:0];
      CFG_DATA_SIZE: seq_cfg.data_size  = value[2:0];
      CFG_CONV_MS:   seq_cfg.conv_ms    = value[15:0];
      CFG_CACHE_MS:  seq_cfg.cache_ms   = value[15:0];
      CFG_TIMEOUT:   seq_cfg.timeout_ms = value[15:0];
      default: ;  // address and command bytes only matter to the bus driver
    endcase
  endtask

  // Waits for the pipe to empty, then writes all registers; bits above each
  // register's width carry junk.
  task automatic write_setting(input logic [6:0] dev, input logic [1:0] len,
                               input logic [23:0] cbytes, input logic [2:0] size,
                               input logic [15:0] conv, cache, tmo);
    s_axis_tvalid_i <= 1'b0;
    while (poll_results_q.size() != 0) @(posedge clk_i);
    write_reg(CFG_DEV_ADDR, {17'($urandom), dev});
    write_reg(CFG_CMD_LEN, {22'($urandom), len});
    write_reg(CFG_CMD_BYTES, cbytes);
    write_reg(CFG_DATA_SIZE, {21'($urandom), size});
    write_reg(CFG_CONV_MS, {8'($urandom), conv});
    write_reg(CFG_CACHE_MS, {8'($urandom), cache});
    write_reg(CFG_TIMEOUT, {8'($urandom), tmo});
    cfg_wr_en_i <= 1'b0;
    time_span = int'(conv) + int'(cache) + int'(tmo) + 4;
  endtask

  // ---------------------------------------------------------------- tests

  // Reset settings: one-byte command, timeouts at 100 ms, error replies.
  task automatic test_register_mode();
    poll(32'd6, 8'd255, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'd106, 8'd255, 1'b0, 1'b1, REPLY_OK, 8'd0, '0);   // exactly at the limit
    poll(32'd107, 8'd255, 1'b0, 1'b1, REPLY_OK, 8'd0, '0);   // one past: timeout
    poll(32'd108, 8'd255, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'd200, 8'd255, 1'b1, 1'b1, 2'd2, 8'd0, '0);       // write start refused
    poll(32'd201, 8'd0, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'hFFFF_FFF0, 8'd0, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'h0000_0050, 8'd0, 1'b0, 1'b1, REPLY_OK, 8'd0, '0);  // elapsed wraps
    poll(32'h0000_0051, 8'd0, 1'b1, 1'b0, REPLY_OK, 8'd0, '0);  // write failed
    poll(32'h0000_0052, 8'd0, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'h0000_0060, 8'd0, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'h0000_0061, 8'd0, 1'b1, 1'b1, 2'd3, 8'd0, '0);      // read start refused
    poll(32'h0000_0062, 8'd0, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
  endtask

  // Command mode through a zero length, oversize data size, conversion wait,
  // busy read start, cache stamped at time zero, cache hits and clamping.
  task automatic test_command_mode();
    write_setting(7'h7F, 2'd0, 24'hFFFFFF, 3'd7, 16'd5, 16'd10, 16'hFFFF);
    poll(32'hFFFF_FFFE, 8'd8, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'hFFFF_FFFF, 8'd8, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'd2, 8'd8, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);          // still converting
    poll(32'd3, 8'd8, 1'b1, 1'b1, REPLY_BUSY, 8'd0, '0);
    poll(32'd3, 8'd8, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'd5, 8'd8, 1'b1, 1'b1, REPLY_OK, 8'd6, 48'h1234_5678_9ABC);
    poll(32'd0, 8'd255, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);        // stamp of zero
    poll(32'd1, 8'd3, 1'b0, 1'b1, REPLY_OK, 8'd0, '0);          // so no cache hit
    poll(32'd20, 8'd3, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'd21, 8'd3, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'd25, 8'd3, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'd26, 8'd3, 1'b1, 1'b1, REPLY_OK, 8'd7, 48'hFFFF_FFFF_FFFF);
    poll(32'd27, 8'd4, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);
    poll(32'd30, 8'd0, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);         // hit, no room
    poll(32'd36, 8'd255, 1'b1, 1'b1, REPLY_OK, 8'd0, '0);       // last fresh ms
    poll(32'd37, 8'd255, 1'b0, 1'b1, REPLY_OK, 8'd0, '0);       // expired
  endtask

  // Random settings: the two extremes first on the first call, then random ones.
  task automatic test_random(input int unsigned gap_pct, stall_pct);
    logic [15:0] conv;
    logic [15:0] cache;
    logic [15:0] tmo;
    int unsigned pick;
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    for (int s = 0; s < 4; s++) begin
      if (setting_no == 0) begin
        write_setting('0, '0, '0, '0, '0, '0, '0);
      end else if (setting_no == 1) begin
        write_setting('1, '1, '1, '1, '1, '1, '1);
      end else begin
        conv  = $urandom_range(1) ? 16'($urandom_range(8)) : 16'($urandom);
        pick  = $urandom_range(2);
        cache = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(20, 1)) : 16'($urandom);
        tmo   = $urandom_range(1) ? 16'($urandom_range(20)) : 16'($urandom);
        write_setting(7'($urandom), 2'($urandom), 24'($urandom), 3'($urandom),
                      conv, cache, tmo);
      end
      setting_no++;
      ms_clock = $urandom_range(1) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
      repeat (PollsPerSetting) send_poll(next_poll());
    end
  endtask

  // Long result stall while polls keep coming: the input side must back up.
  task automatic test_backpressure();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    hold_asked++;
    repeat (40) send_poll(next_poll());
  endtask

  initial begin
    seq_cfg.cmd_len    = 2'd1;
    seq_cfg.data_size  = 3'd1;
    seq_cfg.conv_ms    = 16'd0;
    seq_cfg.cache_ms   = 16'd0;
    seq_cfg.timeout_ms = TimeoutReset;
    src_gap_pct        = 35;
    sink_stall_pct     = 71;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_mode();
    test_command_mode();
    test_random(35, 71);
    test_random(71, 35);
    test_random(0, 0);
    test_backpressure();

    s_axis_tvalid_i <= 1'b0;
    while (poll_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && poll_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
